@@ sv/cfr_pkg.sv @@
// Package for the four-way crossfade router: word types, routing state type,
// fader centres and gain constants. Depends on nothing; every other file imports it.
`default_nettype none

package cfr_pkg;

   localparam int unsigned NumFaders   = 4;
   localparam int unsigned SampleWidth = 10;
   localparam int unsigned LevelWidth  = 14;
   localparam int unsigned GainWidth   = 12;
   localparam int unsigned ScanWidth   = 4;
   localparam int unsigned BusWidth    = 2;

   // Gain law constants.
   localparam logic [11:0] GAIN_BASE       = 12'd333;
   localparam logic [11:0] GAIN_LAMP_LIMIT = 12'd1024;
   localparam logic [11:0] POSITION_OFFSET = 12'd1024;

   // Fader window centres on the combined position axis.
   localparam logic signed [11:0] FADER_CENTRE [NumFaders] =
      '{-12'sd512, -12'sd179, 12'sd179, 12'sd512};

   typedef struct packed {
      logic                   switch_pressed;
      logic [SampleWidth-1:0] cv_sample;
      logic [SampleWidth-1:0] pos_sample;
      logic [SampleWidth-1:0] width_sample;
   } req_type;

   typedef struct packed {
      logic [LevelWidth-1:0] bus_a_level;
      logic [LevelWidth-1:0] bus_b_level;
      logic [LevelWidth-1:0] bus_c_level;
      logic [LevelWidth-1:0] bus_d_level;
      logic [NumFaders-1:0]  lamp_flags;
      logic [ScanWidth-1:0]  next_scan_select;
   } rsp_type;

   // Routing that applies to one word, after any remap it causes.
   typedef struct packed {
      logic [NumFaders-1:0][BusWidth-1:0] fader_bus;
      logic [ScanWidth-1:0]               next_scan;
   } route_type;

endpackage

`default_nettype wire

@@ sv/cfr_req_if.sv @@
// Input channel of the crossfade router: valid/ready handshake with a req_type word.
// Depends on cfr_pkg.
`default_nettype none

interface cfr_req_if
   import cfr_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/cfr_rsp_if.sv @@
// Result channel of the crossfade router: valid/ready handshake with a rsp_type word.
// Depends on cfr_pkg.
`default_nettype none

interface cfr_rsp_if
   import cfr_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/cfr_route.sv @@
// Scan position counter and fader-to-bus routing table with switch remapping.
// Depends on cfr_pkg.
`default_nettype none

module cfr_route
   import cfr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire logic      switch_pressed,
   output route_type      route
);

   localparam logic [1:0] ROW_FADER2 = 2'd0;
   localparam logic [1:0] ROW_FADER3 = 2'd1;
   localparam logic [1:0] ROW_FADER0 = 2'd2;
   localparam logic [1:0] ROW_FADER1 = 2'd3;

   logic [ScanWidth-1:0]               scan_ff;
   logic [ScanWidth-1:0]               scan_in;
   logic [NumFaders-1:0][BusWidth-1:0] table_ff;
   logic [NumFaders-1:0][BusWidth-1:0] table_in;
   logic [1:0]                         row;
   logic [1:0]                         col;

   assign row     = scan_ff[3:2];
   assign col     = scan_ff[1:0];
   assign scan_in = scan_ff + 4'd1;

   always_comb begin
      table_in = table_ff;
      if (switch_pressed) begin
         case (row)
            ROW_FADER2: table_in[2] = 2'd3 - col;
            ROW_FADER3: table_in[3] = 2'd3 - col;
            ROW_FADER0: table_in[0] = col;
            ROW_FADER1: table_in[1] = col;
            default:    table_in    = table_ff;
         endcase
      end
   end

   assign route.fader_bus = table_in;
   assign route.next_scan = scan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         table_ff[0] <= 2'd0;
         table_ff[1] <= 2'd1;
         table_ff[2] <= 2'd2;
         table_ff[3] <= 2'd3;
      end else if (accept) begin
         scan_ff  <= scan_in;
         table_ff <= table_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/cfr_fader_gain.sv @@
// Window gain of one fader from the combined position and the window width.
// Depends on cfr_pkg.
`default_nettype none

module cfr_fader_gain
   import cfr_pkg::*;
(
   input  wire logic signed [11:0]            centre,
   input  wire logic signed [11:0]            position,
   input  wire logic [SampleWidth-1:0]        width,
   output logic [GainWidth-1:0]               gain
);

   logic signed [12:0] diff;
   logic [10:0]        distance;
   logic [20:0]        product;
   logic [11:0]        scaled;
   logic [11:0]        base_less;

   always_comb begin
      diff      = 13'(centre) - 13'(position);
      distance  = diff[12] ? 11'(-diff) : diff[10:0];
      product   = 21'(distance) * 21'(width);
      scaled    = product[20:9];
      base_less = GAIN_BASE - scaled;
      if (scaled >= GAIN_BASE) begin
         gain = '0;
      end else begin
         gain = {base_less[8:0], 3'b000};
      end
   end

endmodule

`default_nettype wire

@@ sv/four_way_crossfade_router_unit.sv @@
// Top level of the four-way crossfade router: input register, gain and bus-sum
// logic, result register. Depends on cfr_pkg, cfr_req_if, cfr_rsp_if, cfr_route
// and cfr_fader_gain.
//
// Usage: each word on req_chan is one control pass carrying the switch bit for
// the current scan position plus cv, position and width samples. Each accepted
// word yields exactly one word on rsp_chan with the four bus levels, the lamp
// flags and the scan position to drive for the following pass.
// An accepted word is held in the input register, and its result is loaded
// into the result register once the result stage is open and is then visible
// on rsp_chan. Throughput is one word per cycle while the receiver keeps
// rsp_chan.ready high; a single pass of four 11x10 multipliers and the bus
// adders lies between the two registers.
// Reset clears both valid flags, sets the scan position to zero and routes
// fader i to bus i. When the receiver stalls, the result register holds its
// word and the input register can still take one more word; req_chan.ready
// drops only while both registers are full and rsp_chan.ready is low.
`default_nettype none

module four_way_crossfade_router_unit
   import cfr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   cfr_req_if.sink    req_chan,
   cfr_rsp_if.source  rsp_chan
);

   // Input stage.
   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_data_ff;
   route_type s1_route_ff;
   logic      s1_advance;
   logic      req_accept;
   route_type route_now;

   // Result stage.
   logic      s2_valid_ff;
   logic      s2_valid_in;
   rsp_type   s2_data_ff;
   rsp_type   s2_data_in;
   logic      s2_open;

   logic signed [11:0]                position;
   logic [SampleWidth:0]              sample_sum;
   logic [NumFaders-1:0][GainWidth-1:0] gain;
   logic [NumFaders-1:0][LevelWidth-1:0] level;
   logic [NumFaders-1:0]              lamps;

   // The result register frees up when empty or when its word is taken, and
   // the input register passes its word on whenever the result stage is open.
   assign s2_open        = !s2_valid_ff || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && s2_open;
   assign req_chan.ready = !s1_valid_ff || s2_open;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The routing table is updated at accept time, so every word sees the
   // remap from its own switch bit and those of all earlier words.
   cfr_route u_route (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .switch_pressed (req_chan.data.switch_pressed),
      .route          (route_now)
   );

   assign s1_valid_in = req_accept || (s1_valid_ff && !s2_open);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff  <= req_chan.data;
         s1_route_ff <= route_now;
      end
   end

   // Combined position is (cv - 512) + (pos - 512), in -1024..1022.
   assign sample_sum = 11'(s1_data_ff.cv_sample) + 11'(s1_data_ff.pos_sample);
   assign position   = signed'(12'(sample_sum) - POSITION_OFFSET);

   for (genvar k = 0; k < NumFaders; k++) begin : g_fader
      cfr_fader_gain u_gain (
         .centre   (FADER_CENTRE[k]),
         .position (position),
         .width    (s1_data_ff.width_sample),
         .gain     (gain[k])
      );
      assign lamps[k] = gain[k] > GAIN_LAMP_LIMIT;
   end

   // Each bus adds the gains of the faders currently routed to it.
   always_comb begin
      for (int b = 0; b < NumFaders; b++) begin
         level[b] = '0;
         for (int k = 0; k < NumFaders; k++) begin
            if (s1_route_ff.fader_bus[k] == BusWidth'(b)) begin
               level[b] = level[b] + LevelWidth'(gain[k]);
            end
         end
      end
   end

   always_comb begin
      s2_data_in.bus_a_level      = level[0];
      s2_data_in.bus_b_level      = level[1];
      s2_data_in.bus_c_level      = level[2];
      s2_data_in.bus_d_level      = level[3];
      s2_data_in.lamp_flags       = lamps;
      s2_data_in.next_scan_select = s1_route_ff.next_scan;
   end

   assign s2_valid_in = s1_advance || (s2_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_chan.valid = s2_valid_ff;
   assign rsp_chan.data  = s2_data_ff;

`ifndef SYNTHESIS
   // Back pressure reaches the input only when both stages are full and stalled.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s2_valid_ff && !rsp_chan.ready))
      else $error("input stalled while a pipeline stage was free");

   // The scan position advances by one for each accepted word and holds otherwise.
   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (route_now.next_scan == $past(route_now.next_scan) + 4'd1))
      else $error("scan position did not advance on accept");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(route_now.next_scan))
      else $error("scan position moved without an accepted word");

   // A word held in the input stage must not change while the result stage is blocked.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_open) |=> (s1_valid_ff && $stable(s1_data_ff)
                                     && $stable(s1_route_ff)))
      else $error("stalled input stage word changed");
`endif

endmodule

`default_nettype wire

@@ verif/tb_four_way_crossfade_router_unit.sv @@
// Self-checking testbench for four_way_crossfade_router_unit: directed and random control
// passes, random idling on both channels, a scoreboard that predicts every result word.
// Depends on cfr_pkg, cfr_req_if, cfr_rsp_if and the router RTL.
`timescale 1ns / 1ps

class fader_mix_tracker;
   localparam int GainBase   = 333;
   localparam int LampLimit  = 1024;
   localparam int AxisOffset = 1024;
   localparam int FaderCentre [4] = '{-512, -179, 179, 512};

   logic [3:0] scan_pos;
   logic [1:0] fader_bus [4];
   cfr_pkg::rsp_type expected_mix [$];
   int error_count;

   function new();
      scan_pos = '0;
      for (int k = 0; k < 4; k++) fader_bus[k] = 2'(k);
      error_count = 0;
   endfunction

   function int unsigned fader_gain(int centre, int position, int width);
      int distance;
      int g;
      distance = centre - position;
      if (distance < 0) distance = -distance;
      g = GainBase - ((distance * width) >> 9);
      if (g < 0) g = 0;
      return int'(g) << 3;
   endfunction

   // Applies the switch remap and scan advance, then predicts the result word.
   function void note_pass(cfr_pkg::req_type w);
      cfr_pkg::rsp_type mix;
      int position;
      int unsigned gain;
      int unsigned bus_sum [4];
      logic [1:0] row;
      logic [1:0] col;
      logic [3:0] lamps;
      row = scan_pos[3:2];
      col = scan_pos[1:0];
      if (w.switch_pressed) begin
         case (row)
            2'd0: fader_bus[2] = 2'd3 - col;
            2'd1: fader_bus[3] = 2'd3 - col;
            2'd2: fader_bus[0] = col;
            default: fader_bus[1] = col;
         endcase
      end
      scan_pos = scan_pos + 4'd1;
      position = int'(w.cv_sample) + int'(w.pos_sample) - AxisOffset;
      lamps = '0;
      for (int k = 0; k < 4; k++) bus_sum[k] = 0;
      for (int k = 0; k < 4; k++) begin
         gain = fader_gain(FaderCentre[k], position, int'(w.width_sample));
         if (gain > LampLimit) lamps[k] = 1'b1;
         bus_sum[fader_bus[k]] += gain;
      end
      mix.bus_a_level      = 14'(bus_sum[0]);
      mix.bus_b_level      = 14'(bus_sum[1]);
      mix.bus_c_level      = 14'(bus_sum[2]);
      mix.bus_d_level      = 14'(bus_sum[3]);
      mix.lamp_flags       = lamps;
      mix.next_scan_select = scan_pos;
      expected_mix.push_back(mix);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function void check_levels(cfr_pkg::rsp_type got);
      cfr_pkg::rsp_type want;
      if (expected_mix.size() == 0) begin
         $error("result word with no pass waiting for it");
         error_count++;
         return;
      end
      want = expected_mix.pop_front();
      compare_field("bus_a_level", want.bus_a_level, got.bus_a_level);
      compare_field("bus_b_level", want.bus_b_level, got.bus_b_level);
      compare_field("bus_c_level", want.bus_c_level, got.bus_c_level);
      compare_field("bus_d_level", want.bus_d_level, got.bus_d_level);
      compare_field("lamp_flags", want.lamp_flags, got.lamp_flags);
      compare_field("next_scan_select", want.next_scan_select, got.next_scan_select);
   endfunction

   function int pending();
      return expected_mix.size();
   endfunction
endclass

module tb_four_way_crossfade_router_unit;
   import cfr_pkg::*;

   // Number of random passes after the directed ones.
   localparam int RandomPasses = 1600;
   // Cycles without any accepted word before the run is declared hung. The longest
   // legitimate quiet stretch is the deliberate receiver hold-off below.
   localparam int IdleLimit    = 4000;
   // Result words accepted before the receiver starts its long hold-off.
   localparam int HoldAfter    = 500;
   localparam int HoldCycles   = 320;
   // Extra wait after the last expected result, leaving ample margin to catch stray words.
   localparam int DrainCycles  = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfr_req_if req_chan ();
   cfr_rsp_if rsp_chan ();

   four_way_crossfade_router_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   fader_mix_tracker mix_board;
   req_type pass_list [$];
   int quiet_cycles = 0;

   // Both sides share this rule for idling: in every fourth block of 150 words the
   // side runs flat out, otherwise it waits before each word for a gap drawn with $urandom_range.
   function automatic int idle_draw(int n);
      if ((n / 150) % 4 == 3) return 0;
      return $urandom_range(0, 11);
   endfunction

   // A sample biased toward the edges of the range and the middle of the axis, so the
   // fader windows are hit often and both rails are exercised.
   function automatic logic [9:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return 10'd1023;
         2: return 10'($urandom_range(448, 575));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic req_type make_pass(logic p, int cv, int pos, int wd);
      req_type w;
      w.switch_pressed = p;
      w.cv_sample      = 10'(cv);
      w.pos_sample     = 10'(pos);
      w.width_sample   = 10'(wd);
      return w;
   endfunction

   task automatic build_passes();
      req_type w;
      // All samples at zero: position at the low rail, zero width gives every fader
      // its full gain, so each bus carries exactly one full fader.
      pass_list.push_back(make_pass(1'b0, 0, 0, 0));
      // Every field at its maximum, with the switch closed.
      pass_list.push_back(make_pass(1'b1, 1023, 1023, 1023));
      // Position exactly on each fader centre with the narrowest window.
      pass_list.push_back(make_pass(1'b0, 0, 512, 1023));
      pass_list.push_back(make_pass(1'b0, 333, 512, 1023));
      pass_list.push_back(make_pass(1'b0, 691, 512, 1023));
      pass_list.push_back(make_pass(1'b0, 1023, 513, 1023));
      // Gain exactly at the lamp limit (not lit), then one step above it (lit).
      pass_list.push_back(make_pass(1'b0, 819, 512, 512));
      pass_list.push_back(make_pass(1'b0, 820, 512, 512));
      // Far from every centre so that all gains clip to zero.
      pass_list.push_back(make_pass(1'b0, 1023, 0, 1023));
      // Sixteen closed switches in a row: the scan visits every row and column, so
      // every remap case is taken once.
      for (int k = 0; k < 16; k++) begin
         pass_list.push_back(make_pass(1'b1, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                       $urandom_range(0, 255)));
      end
      for (int k = 0; k < RandomPasses; k++) begin
         w.switch_pressed = ($urandom_range(0, 3) == 0);
         w.cv_sample      = pick_sample();
         w.pos_sample     = pick_sample();
         // Small width samples are common: they widen the windows so several faders carry gain.
         if ($urandom_range(0, 2) == 0) w.width_sample = 10'($urandom_range(0, 127));
         else w.width_sample = pick_sample();
         pass_list.push_back(w);
      end
   endtask

   // Sender: offers each pass after a random gap. Valid stays high across
   // back-to-back words rather than being lowered and raised in one step.
   task automatic drive_passes();
      int gap;
      for (int idx = 0; idx < pass_list.size(); idx++) begin
         gap = idle_draw(idx);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.data  <= pass_list[idx];
         do @(posedge clock); while (!req_chan.ready);
      end
      req_chan.valid <= 1'b0;
   endtask

   // Receiver: stalls a random number of cycles before each word. Once, it holds
   // ready low for a long stretch so both registers fill and the input stalls
   // while the sender keeps offering.
   task automatic drain_results();
      int stall;
      int taken;
      taken = 0;
      forever begin
         stall = idle_draw(taken);
         if (taken == HoldAfter) stall = HoldCycles;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   endtask

   // Monitor: both channels are sampled at the rising edge, before any of this edge's
   // nonblocking updates land. A pass is noted before a result is checked, so a
   // result can only ever be matched against an earlier or the same edge's pass.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) mix_board.note_pass(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) mix_board.check_levels(rsp_chan.data);
      end
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      mix_board = new();
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      rsp_chan.ready <= 1'b0;
      build_passes();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none
      drive_passes();
      // Every pass is in; wait for the last results, then watch for strays.
      while (mix_board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mix_board.error_count == 0 && mix_board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
sv/cfr_pkg.sv
sv/cfr_req_if.sv
sv/cfr_rsp_if.sv
sv/cfr_route.sv
sv/cfr_fader_gain.sv
sv/four_way_crossfade_router_unit.sv
verif/tb_four_way_crossfade_router_unit.sv
